// ----- src/seb_pkg.sv -----
// Shared types and codes for the sparse extent block store.
package seb_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  localparam logic [1:0] CFG_DISK_BLOCKS = 2'd0;
  localparam logic [1:0] CFG_EXTENT_SIZE = 2'd1;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_step;
    logic       map_rd;
    logic       map_clr;
    logic       map_hit;
    logic       alloc;
    logic       pclr;
    logic       addr_calc;
    logic       pool_acc;
    logic       out_load;
    logic [1:0] res_status;
    logic       res_mem;
  } seb_cmd_t;

  typedef struct packed {
    logic cfg_wr;
    logic range_err;
    logic div_done;
    logic map_valid;
    logic is_write;
    logic pool_fit;
    logic clr_last;
    logic pclr_last;
  } seb_stat_t;

endpackage

// ----- src/seb_ctrl.sv -----
// Controller: sequences range check, divide, map lookup, extent clear and pool access.
module seb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  seb_pkg::seb_stat_t stat,
  output seb_pkg::seb_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_MAPRD, S_MAPCHK, S_PCLR, S_ADDR, S_ACC, S_FINISH
  } state_t;

  state_t     state_r;
  logic       out_valid_r;
  logic [1:0] res_status_r;
  logic       res_mem_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.res_status = res_status_r;
    cmd.res_mem    = res_mem_r;
    unique case (state_r)
      S_CLEAR:  cmd.map_clr = 1'b1;
      S_IDLE:   cmd.load = in_valid;
      S_CHECK:  cmd.div_start = !stat.range_err;
      S_DIV:    cmd.div_step = !stat.div_done;
      S_MAPRD:  cmd.map_rd = 1'b1;
      S_MAPCHK: begin
        cmd.map_hit = stat.map_valid;
        cmd.alloc   = !stat.map_valid && stat.is_write && stat.pool_fit;
      end
      S_PCLR:   cmd.pclr = 1'b1;
      S_ADDR:   cmd.addr_calc = 1'b1;
      S_ACC:    cmd.pool_acc = 1'b1;
      S_FINISH: cmd.out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_valid_r  <= 1'b0;
      res_status_r <= seb_pkg::ST_OK;
      res_mem_r    <= 1'b0;
    end else begin
      // S_FINISH refills the output register itself
      if (out_valid_r && out_ready && (stat.cfg_wr || state_r != S_FINISH))
        out_valid_r <= 1'b0;
      priority if (stat.cfg_wr) begin
        state_r <= S_CLEAR;
      end else begin
        unique case (state_r)
          S_CLEAR: if (stat.clr_last) state_r <= S_IDLE;
          S_IDLE: if (in_valid) state_r <= S_CHECK;
          S_CHECK: begin
            if (stat.range_err) begin
              res_status_r <= seb_pkg::ST_RANGE;
              res_mem_r    <= 1'b0;
              state_r      <= S_FINISH;
            end else begin
              state_r <= S_DIV;
            end
          end
          S_DIV: if (stat.div_done) state_r <= S_MAPRD;
          S_MAPRD: state_r <= S_MAPCHK;
          S_MAPCHK: begin
            priority if (stat.map_valid) begin
              res_status_r <= seb_pkg::ST_OK;
              res_mem_r    <= !stat.is_write;
              state_r      <= S_ADDR;
            end else if (!stat.is_write) begin
              res_status_r <= seb_pkg::ST_OK;
              res_mem_r    <= 1'b0;
              state_r      <= S_FINISH;
            end else if (!stat.pool_fit) begin
              res_status_r <= seb_pkg::ST_NOSPACE;
              res_mem_r    <= 1'b0;
              state_r      <= S_FINISH;
            end else begin
              res_status_r <= seb_pkg::ST_OK;
              res_mem_r    <= 1'b0;
              state_r      <= S_PCLR;
            end
          end
          S_PCLR: if (stat.pclr_last) state_r <= S_ADDR;
          S_ADDR: state_r <= S_ACC;
          S_ACC: state_r <= S_FINISH;
          S_FINISH: begin
            if (!out_valid_r || out_ready) begin
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
          default: state_r <= S_CLEAR;
        endcase
      end
    end
  end

endmodule

// ----- src/seb_datapath.sv -----
// Datapath: config registers, divider, extent map, pool memory and result registers.
module seb_datapath #(
  parameter int BLOCK_WORDS = 128,
  parameter int MAX_BLOCKS  = 4096,
  parameter int POOL_WORDS  = 65536
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_command,
  input  logic [11:0]        in_block_address,
  input  logic [6:0]         in_word_offset,
  input  logic [31:0]        in_write_word,
  output logic [31:0]        out_read_word,
  output logic [1:0]         out_status,
  input  seb_pkg::seb_cmd_t  cmd,
  output seb_pkg::seb_stat_t stat
);

  localparam int MAP_AW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int POOL_AW = $clog2(POOL_WORDS);
  localparam int NFW_W   = $clog2(POOL_WORDS + 1);
  localparam int BW_W    = $clog2(BLOCK_WORDS + 1);
  localparam int EXT_W   = 13 + BW_W;
  localparam int SUM_W   = ((NFW_W > EXT_W) ? NFW_W : EXT_W) + 1;
  localparam int ADR_W   = ((POOL_AW > EXT_W) ? POOL_AW : EXT_W) + 2;

  logic [12:0] disk_blocks_r, extent_size_r, eff_blocks_r, eff_ext_r;
  logic [12:0] eff_blocks_nxt, eff_ext_nxt, ext_min;
  logic [EXT_W-1:0] ext_words_r;
  logic [NFW_W-1:0] nfw_r;

  logic        cmd_r;
  logic [11:0] lba_r;
  logic [6:0]  word_r;
  logic [31:0] wdata_r;

  logic [12:0] rem_r;
  logic [11:0] quo_r;
  logic [3:0]  div_cnt_r;
  logic [13:0] div_sh, div_sub;

  logic [MAP_AW-1:0]  clr_cnt_r, slot_idx;
  logic [MAP_AW+11:0] slot_wide;
  logic [POOL_AW:0]   map_mem [MAX_BLOCKS];
  logic [POOL_AW:0]   map_rdata_r;

  logic [POOL_AW-1:0] base_r, addr_r, pclr_addr;
  logic [EXT_W-1:0]   pcnt_r;
  logic [ADR_W-1:0]   addr_sum, pclr_sum;
  logic [31:0]        pool_mem [POOL_WORDS];
  logic [31:0]        pool_rdata_r;
  logic [SUM_W-1:0]   fit_sum;
  logic [31:0]        out_read_word_r;
  logic [1:0]         out_status_r;

  assign stat.cfg_wr = cfg_valid &&
    (cfg_index == seb_pkg::CFG_DISK_BLOCKS || cfg_index == seb_pkg::CFG_EXTENT_SIZE);

  always_comb begin
    eff_blocks_nxt = ({19'd0, disk_blocks_r} < 32'(MAX_BLOCKS)) ? disk_blocks_r
                                                               : 13'(MAX_BLOCKS);
    ext_min     = (extent_size_r < eff_blocks_r) ? extent_size_r : eff_blocks_r;
    eff_ext_nxt = (ext_min == 13'd0) ? 13'd1 : ext_min;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_blocks_r <= 13'd4096;
      extent_size_r <= 13'd16;
      nfw_r         <= '0;
      clr_cnt_r     <= '0;
    end else begin
      if (cfg_valid && cfg_index == seb_pkg::CFG_DISK_BLOCKS) disk_blocks_r <= cfg_data;
      if (cfg_valid && cfg_index == seb_pkg::CFG_EXTENT_SIZE) extent_size_r <= cfg_data;
      if (stat.cfg_wr) begin
        nfw_r     <= '0;
        clr_cnt_r <= '0;
      end else begin
        if (cmd.alloc) nfw_r <= NFW_W'(nfw_r + ext_words_r);
        if (cmd.map_clr) clr_cnt_r <= clr_cnt_r + 1'b1;
      end
    end
  end

  // Geometry follows the config registers; stable long before any transaction.
  always_ff @(posedge clk) begin
    eff_blocks_r <= eff_blocks_nxt;
    eff_ext_r    <= eff_ext_nxt;
    ext_words_r  <= EXT_W'(eff_ext_r * BLOCK_WORDS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r   <= in_command;
      lba_r   <= in_block_address;
      word_r  <= in_word_offset;
      wdata_r <= in_write_word;
    end
  end

  assign stat.range_err = ({1'b0, lba_r} >= eff_blocks_r) ||
                          ({25'd0, word_r} >= 32'(BLOCK_WORDS));
  assign stat.is_write  = cmd_r;

  // Restoring divider, one quotient bit per cycle.
  assign div_sh  = {rem_r, quo_r[11]};
  assign div_sub = div_sh - {1'b0, eff_ext_r};
  assign stat.div_done = (div_cnt_r == 4'd12);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r     <= '0;
      quo_r     <= lba_r;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (div_sh >= {1'b0, eff_ext_r}) begin
        rem_r <= div_sub[12:0];
        quo_r <= {quo_r[10:0], 1'b1};
      end else begin
        rem_r <= div_sh[12:0];
        quo_r <= {quo_r[10:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r + 4'd1;
    end
  end

  assign slot_wide = {{MAP_AW{1'b0}}, quo_r};
  assign slot_idx  = slot_wide[MAP_AW-1:0];
  assign stat.clr_last  = (clr_cnt_r == MAP_AW'(MAX_BLOCKS - 1));
  assign stat.map_valid = map_rdata_r[POOL_AW];

  always_ff @(posedge clk) begin
    if (cmd.map_clr) begin
      map_mem[clr_cnt_r] <= '0;
    end else if (cmd.alloc) begin
      map_mem[slot_idx] <= {1'b1, nfw_r[POOL_AW-1:0]};
    end
    if (cmd.map_rd) map_rdata_r <= map_mem[slot_idx];
  end

  assign fit_sum = SUM_W'(nfw_r) + SUM_W'(ext_words_r);
  assign stat.pool_fit = ({{(32-SUM_W){1'b0}}, fit_sum} <= 32'(POOL_WORDS));

  assign pclr_sum  = ADR_W'(base_r) + ADR_W'(pcnt_r);
  assign pclr_addr = pclr_sum[POOL_AW-1:0];
  assign stat.pclr_last = (pcnt_r == ext_words_r - 1'b1);
  assign addr_sum  = ADR_W'(base_r) + ADR_W'(rem_r * BLOCK_WORDS) + ADR_W'(word_r);

  always_ff @(posedge clk) begin
    if (cmd.map_hit) base_r <= map_rdata_r[POOL_AW-1:0];
    if (cmd.alloc) begin
      base_r <= nfw_r[POOL_AW-1:0];
      pcnt_r <= '0;
    end else if (cmd.pclr) begin
      pcnt_r <= pcnt_r + 1'b1;
    end
    if (cmd.addr_calc) addr_r <= addr_sum[POOL_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.pclr) begin
      pool_mem[pclr_addr] <= '0;
    end else if (cmd.pool_acc && cmd_r) begin
      pool_mem[addr_r] <= wdata_r;
    end
    if (cmd.pool_acc && !cmd_r) pool_rdata_r <= pool_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_word_r <= cmd.res_mem ? pool_rdata_r : 32'd0;
      out_status_r    <= cmd.res_status;
    end
  end

  assign out_read_word = out_read_word_r;
  assign out_status    = out_status_r;

endmodule

// ----- src/sparse_extent_block_store.sv -----
// Top level of the sparse extent block store.
// One word transaction at a time: an in-range access to a mapped extent passes through
// the 12-step restoring divider that maps the block to its extent, the registered extent
// map read and the registered pool access before its result. A read of an unallocated
// extent and a no-space write return after the map lookup, a range error after the range
// check. The first write into an extent also clears the new extent, one pool word per
// cycle, before the pool access. A result that finds the output register still occupied
// waits until it drains.
// After reset and after every write to a geometry register the extent map is swept
// clear; no transaction is accepted during the sweep, while configuration writes are
// always taken. A finished result waits in an output register while the next
// transaction is accepted.
module sparse_extent_block_store #(
  parameter int BLOCK_WORDS = 128,
  parameter int MAX_BLOCKS  = 4096,
  parameter int POOL_WORDS  = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [11:0] in_block_address,
  input  logic [6:0]  in_word_offset,
  input  logic [31:0] in_write_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_word,
  output logic [1:0]  out_status
);

  seb_pkg::seb_cmd_t  cmd;
  seb_pkg::seb_stat_t stat;

  assign cfg_ready = 1'b1;

  seb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  seb_datapath #(
    .BLOCK_WORDS (BLOCK_WORDS),
    .MAX_BLOCKS  (MAX_BLOCKS),
    .POOL_WORDS  (POOL_WORDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_command       (in_command),
    .in_block_address (in_block_address),
    .in_word_offset   (in_word_offset),
    .in_write_word    (in_write_word),
    .out_read_word    (out_read_word),
    .out_status       (out_status),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// ----- src/seb_checker.sv -----
// Port-level assertions for the sparse extent block store, with bind.
module seb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_word,
  input logic [1:0]  out_status
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == seb_pkg::ST_OK || out_status == seb_pkg::ST_RANGE ||
                   out_status == seb_pkg::ST_NOSPACE))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != seb_pkg::ST_OK) |-> (out_read_word == 32'd0))
    else $error("error result carries data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_read_word) &&
                                   $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind sparse_extent_block_store seb_checker u_seb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_word (out_read_word),
  .out_status    (out_status)
);

// ----- sim/testbench.sv -----
// Testbench for the sparse extent block store: directed table, then random phases.
module testbench;

  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 300000;
  localparam int DISK_MAX = 4096;
  localparam int WORDS_PER_BLOCK = 128;
  localparam int POOL_SIZE = 65536;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [12:0] val;
    bit          cmd;
    logic [11:0] blk;
    logic [6:0]  off;
    logic [31:0] data;
    bit          typed;
    logic [31:0] t_word;
    logic [1:0]  t_status;
  } stim_row_t;

  typedef struct {
    logic [31:0] word;
    logic [1:0]  status;
  } access_result_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_command = 0;
  logic [11:0] in_block_address = '0;
  logic [6:0]  in_word_offset = '0;
  logic [31:0] in_write_word = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_read_word;
  logic [1:0]  out_status;

  sparse_extent_block_store i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_block_address(in_block_address), .in_word_offset(in_word_offset),
    .in_write_word(in_write_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_read_word(out_read_word),
    .out_status(out_status)
  );

  always #1 clk = ~clk;

  // Shadow of the store
  logic [12:0] disk_blocks_q;
  logic [12:0] extent_size_q;
  bit          map_valid[DISK_MAX];
  int unsigned map_base[DISK_MAX];
  int unsigned next_free;
  logic [31:0] pool_words[POOL_SIZE];

  access_result_t pending_q[$];
  stim_row_t      table_q[$];
  logic [11:0]    wr_blk_q[$];
  logic [6:0]     wr_off_q[$];

  int  errors = 0;
  int  n_items = 0, n_reads = 0, n_writes = 0, n_range = 0, n_nospace = 0, n_cfg = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1;

  function automatic int unsigned eff_disk();
    return (disk_blocks_q > DISK_MAX) ? DISK_MAX : disk_blocks_q;
  endfunction

  function automatic int unsigned eff_extent();
    int unsigned e;
    e = (extent_size_q < eff_disk()) ? extent_size_q : eff_disk();
    return (e == 0) ? 1 : e;
  endfunction

  function automatic void clear_map();
    for (int i = 0; i < DISK_MAX; i++) map_valid[i] = 0;
    next_free = 0;
  endfunction

  function automatic access_result_t predict_access(bit cmd, logic [11:0] blk,
                                                    logic [6:0] off, logic [31:0] data);
    access_result_t r;
    int unsigned e, slot, ext_words, addr;
    r.word = '0;
    r.status = seb_pkg::ST_OK;
    if (blk >= eff_disk() || off >= WORDS_PER_BLOCK) begin
      r.status = seb_pkg::ST_RANGE;
      return r;
    end
    e = eff_extent();
    slot = blk / e;
    ext_words = e * WORDS_PER_BLOCK;
    if (!map_valid[slot]) begin
      if (!cmd) return r;
      if (next_free + ext_words > POOL_SIZE) begin
        r.status = seb_pkg::ST_NOSPACE;
        return r;
      end
      for (int unsigned i = 0; i < ext_words; i++) pool_words[next_free + i] = '0;
      map_valid[slot] = 1;
      map_base[slot] = next_free;
      next_free += ext_words;
    end
    addr = (map_base[slot] + (blk - slot * e) * WORDS_PER_BLOCK + off) % POOL_SIZE;
    if (cmd) pool_words[addr] = data;
    else r.word = pool_words[addr];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_cfg(logic [1:0] idx, logic [12:0] val);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1; s.idx = idx; s.val = val;
    table_q.push_back(s);
  endtask

  task automatic add_item(bit cmd, logic [11:0] blk, logic [6:0] off, logic [31:0] data,
                          bit typed = 0, logic [31:0] tw = '0,
                          logic [1:0] ts = seb_pkg::ST_OK);
    stim_row_t s;
    s = '{default: '0};
    s.cmd = cmd; s.blk = blk; s.off = off; s.data = data;
    s.typed = typed; s.t_word = tw; s.t_status = ts;
    table_q.push_back(s);
  endtask

  // Entered and left at a rising edge; valid stays up when the next transaction follows at once.
  task automatic send_access(bit cmd, logic [11:0] blk, logic [6:0] off, logic [31:0] data,
                             bit typed = 0, logic [31:0] tw = '0,
                             logic [1:0] ts = seb_pkg::ST_OK);
    access_result_t r;
    int gap;
    in_valid <= 1;
    in_command <= cmd;
    in_block_address <= blk;
    in_word_offset <= off;
    in_write_word <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_access(cmd, blk, off, data);
    if (typed) begin
      r.word = tw;
      r.status = ts;
    end
    pending_q.push_back(r);
    n_items++;
    if (cmd) n_writes++; else n_reads++;
    if (r.status == seb_pkg::ST_RANGE) n_range++;
    if (r.status == seb_pkg::ST_NOSPACE) n_nospace++;
    if (cmd && r.status == seb_pkg::ST_OK) begin
      wr_blk_q.push_back(blk);
      wr_off_q.push_back(off);
      if (wr_blk_q.size() > 64) begin
        void'(wr_blk_q.pop_front());
        void'(wr_off_q.pop_front());
      end
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every result has come back.
  task automatic drain();
    if (in_valid) in_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    n_cfg++;
    if (idx == seb_pkg::CFG_DISK_BLOCKS) begin
      disk_blocks_q = val;
      clear_map();
    end else if (idx == seb_pkg::CFG_EXTENT_SIZE) begin
      extent_size_q = val;
      clear_map();
    end
    wr_blk_q.delete();
    wr_off_q.delete();
    @(posedge clk);
  endtask

  task automatic random_phase(logic [12:0] disk, logic [12:0] ext, int count, int window);
    int r, k;
    bit cmd;
    logic [11:0] blk;
    logic [6:0] off;
    logic [31:0] data;
    write_reg(seb_pkg::CFG_DISK_BLOCKS, disk);
    write_reg(seb_pkg::CFG_EXTENT_SIZE, ext);
    gaps_on = $urandom_range(0, 3) != 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      off = $urandom;
      cmd = $urandom_range(0, 1);
      if (r < 30 && wr_blk_q.size() != 0) begin
        k = $urandom_range(0, wr_blk_q.size() - 1);
        blk = wr_blk_q[k];
        off = wr_off_q[k];
        cmd = 0;
      end else if (r < 45 || eff_disk() == 0) begin
        blk = $urandom;
      end else begin
        blk = $urandom_range(0, ((eff_disk() < window) ? eff_disk() : window) - 1);
      end
      case ($urandom_range(0, 9))
        0: data = '0;
        1: data = '1;
        default: data = $urandom;
      endcase
      send_access(cmd, blk, off, data);
      if (n == count / 2 && $urandom_range(0, 1)) drain();
    end
  endtask

  // Result checking
  always @(posedge clk) begin
    access_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result without a pending transaction: read_word %h status %0d",
               out_read_word, out_status);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_read_word !== e.word) begin
          $error("read_word: expected %h, got %h", e.word, out_read_word);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on) out_ready <= 1;
    else if (r < 60) out_ready <= 1;
    else if (r < 97) out_ready <= 0;
    else out_ready <= ~out_ready;
  end

  // Watchdog on transactions
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    disk_blocks_q = 13'd4096;
    extent_size_q = 13'd16;
    clear_map();
    for (int i = 0; i < POOL_SIZE; i++) pool_words[i] = '0;

    add_item(0, 12'd0, 7'd0, 32'h0, 1, 32'h0, seb_pkg::ST_OK);
    add_item(1, 12'd4095, 7'd127, 32'hffffffff, 1, 32'h0, seb_pkg::ST_OK);
    add_item(0, 12'd4095, 7'd127, 32'h0, 1, 32'hffffffff, seb_pkg::ST_OK);
    add_item(0, 12'd4095, 7'd0, 32'h0, 1, 32'h0, seb_pkg::ST_OK);
    add_item(1, 12'd0, 7'd0, 32'ha5a5a5a5);
    add_item(0, 12'd0, 7'd0, 32'h0);
    add_cfg(seb_pkg::CFG_DISK_BLOCKS, 13'd100);
    add_item(0, 12'd99, 7'd5, 32'h0, 1, 32'h0, seb_pkg::ST_OK);
    add_item(1, 12'd100, 7'd0, 32'h1, 1, 32'h0, seb_pkg::ST_RANGE);
    add_item(0, 12'd4095, 7'd0, 32'h0, 1, 32'h0, seb_pkg::ST_RANGE);
    add_cfg(seb_pkg::CFG_DISK_BLOCKS, 13'd0);
    add_item(1, 12'd0, 7'd0, 32'h5, 1, 32'h0, seb_pkg::ST_RANGE);
    add_cfg(seb_pkg::CFG_DISK_BLOCKS, 13'd8191);
    add_cfg(seb_pkg::CFG_EXTENT_SIZE, 13'd0);
    add_item(1, 12'd1, 7'd3, 32'h12345678);
    add_item(0, 12'd1, 7'd3, 32'h0);
    add_cfg(seb_pkg::CFG_EXTENT_SIZE, 13'd4096);
    add_item(1, 12'd7, 7'd1, 32'hdeadbeef, 1, 32'h0, seb_pkg::ST_NOSPACE);
    add_item(0, 12'd7, 7'd1, 32'h0, 1, 32'h0, seb_pkg::ST_OK);
    add_cfg(seb_pkg::CFG_EXTENT_SIZE, 13'd512);
    add_item(1, 12'd600, 7'd2, 32'h0badf00d);
    add_item(1, 12'd0, 7'd0, 32'h1, 1, 32'h0, seb_pkg::ST_NOSPACE);
    add_cfg(CFG_SPARE, 13'd5);
    add_item(0, 12'd600, 7'd2, 32'h0);

    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (table_q[i]) begin
      if (table_q[i].is_cfg) write_reg(table_q[i].idx, table_q[i].val);
      else send_access(table_q[i].cmd, table_q[i].blk, table_q[i].off, table_q[i].data,
                       table_q[i].typed, table_q[i].t_word, table_q[i].t_status);
    end

    random_phase(13'd4096, 13'd16, 200, 48);
    random_phase(13'd300, 13'd7, 150, 300);
    random_phase(13'd4096, 13'd64, 150, 4096);
    random_phase(13'd1, 13'd1, 80, 1);
    random_phase(13'd8191, 13'd8191, 80, 64);
    random_phase(13'd37, 13'd4096, 120, 37);
    random_phase(13'd4096, 13'd1, 250, 40);

    drain();
    repeat (30) @(posedge clk);
    $display("covered %0d accesses (%0d reads, %0d writes), %0d register writes",
             n_items, n_reads, n_writes, n_cfg);
    $display("range errors %0d, pool exhausted %0d", n_range, n_nospace);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
